/* rtl/man_pkg.sv */
// Shared types, widths and constants of the median/average normalizer.
package man_pkg;

  localparam int CH_W        = 3;
  localparam int SAMPLE_W    = 12;
  localparam int AVG_W       = 16;
  localparam int LEVEL_W     = 10;
  localparam int SUM_W       = 18;
  localparam int GCOUNT_W    = 7;
  localparam int FRAC_W      = 4;
  localparam int PHASE_W     = 2;
  localparam int DIV_W       = 23;  // dividend and quotient width of the serial divider
  localparam int DIVISOR_W   = 16;
  localparam int STEP_W      = 5;   // holds DIV_W
  localparam int ADDR_W      = 3;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam int GROUPS_DEF       = 8;
  localparam int NUM_CHANNELS_DEF = 6;

  localparam int PERCENT_SCALE = 100;
  localparam int LEVEL_MAX     = 1023;

  // register index of the phase register
  localparam logic [0:0] REG_PHASE = 1'b0;

  localparam logic [PHASE_W-1:0] PHASE_ZERO    = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_PEAK    = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_MEASURE = 2'd2;

  // completed averaging group handed from front to back
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_W-1:0]     numer;
    logic [DIVISOR_W-1:0] denom;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_AVG,
    BK_APPLY,
    BK_MUL,
    BK_LVL_GO,
    BK_DIV_LVL,
    BK_EMIT
  } back_state_t;

endpackage

/* rtl/man_stream_if.sv */
// Valid/ready stream interfaces for samples in and results out.
interface man_in_if;
  logic                         valid;
  logic                         ready;
  logic [man_pkg::CH_W-1:0]     channel;
  logic [man_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

interface man_out_if;
  logic                        valid;
  logic                        ready;
  logic [man_pkg::CH_W-1:0]    out_channel;
  logic [man_pkg::AVG_W-1:0]   average;
  logic [man_pkg::LEVEL_W-1:0] level;
  logic                        saturated;
  logic                        peak_zero;

  modport source (output valid, out_channel, average, level, saturated, peak_zero,
                  input ready);
  modport sink   (input valid, out_channel, average, level, saturated, peak_zero,
                  output ready);
endinterface

/* rtl/median_average_normalizer_core.sv */
// Top level of the median/average normalizer.
//
//   port group   dir   transfer when                  payload
//   samples      in    valid & ready                  channel, sample
//   results      out   valid & ready                  out_channel, average, level,
//                                                     saturated, peak_zero
//   APB (p*)     in    psel & penable & pwrite        phase at paddr 0
//
// Each sample is taken as it transfers: the front updates the channel's triple,
// median sum and group count in the transfer cycle. Every GROUPS medians it
// queues one job (queue depth 2); samples stall only while the queue is full.
// The back half forms the average with a reciprocal multiply and, in measure
// phase with a nonzero peak and the average above the offset, runs the level
// through the serial divider.
// A finished result sits in an output register; the back can start the next
// job once the result is loaded. Reset clears all counts, sums, offsets,
// peaks and the phase (no clearing pass).
module median_average_normalizer_core #(
  parameter int GROUPS       = man_pkg::GROUPS_DEF,
  parameter int NUM_CHANNELS = man_pkg::NUM_CHANNELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  man_in_if.sink                     samples,
  man_out_if.source                  results,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [man_pkg::ADDR_W-1:0] paddr,
  input  logic [man_pkg::DATA_W-1:0] pwdata,
  output logic [man_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int JOB_W = $bits(man_pkg::job_t);

  logic [man_pkg::PHASE_W-1:0] phase;
  logic                        sel_phase;

  logic              fr_valid;
  logic              fr_ready;
  man_pkg::job_t     fr_job;
  logic              bk_valid;
  logic              bk_ready;
  logic [JOB_W-1:0]  bk_bits;
  man_pkg::job_t     bk_job;
  man_pkg::div_req_t div_req;
  man_pkg::div_rsp_t div_rsp;

  // config port: word index sits at paddr[2], no wait states
  assign pready    = 1'b1;
  assign sel_phase = paddr[2] == man_pkg::REG_PHASE;
  assign prdata    = sel_phase ? man_pkg::DATA_W'(phase) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= man_pkg::PHASE_ZERO;
    end else if (psel && penable && pwrite && sel_phase) begin
      phase <= pwdata[man_pkg::PHASE_W-1:0];
    end
  end

  man_front #(
    .GROUPS       (GROUPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  man_queue #(
    .WIDTH (JOB_W),
    .DEPTH (man_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_data   (bk_bits)
  );

  assign bk_job = man_pkg::job_t'(bk_bits);

  man_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  man_back #(
    .GROUPS       (GROUPS),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .phase     (phase),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .results   (results)
  );

endmodule

/* rtl/man_div.sv */
// Restoring divider, one quotient bit per cycle.
module man_div (
  input  logic              clk,
  input  logic              rst,
  input  man_pkg::div_req_t req,
  output man_pkg::div_rsp_t rsp
);

  localparam int DW = man_pkg::DIV_W;
  localparam int VW = man_pkg::DIVISOR_W;

  logic                       busy;
  logic                       done;
  logic [man_pkg::STEP_W-1:0] count;
  logic [VW-1:0]              rem;
  logic [VW-1:0]              denom;
  logic [DW-1:0]              nq;      // dividend shifting out, quotient shifting in

  logic [VW:0] shifted;
  logic [VW:0] trial;
  logic        fits;

  assign shifted = {rem, nq[DW-1]};
  assign trial   = shifted - {1'b0, denom};
  assign fits    = shifted >= {1'b0, denom};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && count == man_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      count <= man_pkg::STEP_W'(DW);
      rem   <= '0;
      denom <= req.denom;
      nq    <= req.numer;
    end else if (busy) begin
      count <= count - man_pkg::STEP_W'(1);
      rem   <= fits ? trial[VW-1:0] : shifted[VW-1:0];
      nq    <= {nq[DW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = nq;

endmodule

/* rtl/man_queue.sv */
// Small FIFO between the front and back halves.
module man_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = man_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = count != CNT_W'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/man_front.sv */
// Front half: per-channel triple window, median and group accumulation.
module man_front #(
  parameter int GROUPS       = man_pkg::GROUPS_DEF,
  parameter int NUM_CHANNELS = man_pkg::NUM_CHANNELS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  man_in_if.sink        samples,
  output logic          job_valid,
  input  logic          job_ready,
  output man_pkg::job_t job
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW    = man_pkg::SAMPLE_W;

  logic [SW-1:0]                win0   [NUM_CHANNELS];
  logic [SW-1:0]                win1   [NUM_CHANNELS];
  logic [1:0]                   slot   [NUM_CHANNELS];
  logic [man_pkg::GCOUNT_W-1:0] gcount [NUM_CHANNELS];
  logic [man_pkg::SUM_W-1:0]    msum   [NUM_CHANNELS];

  logic                      xfer;
  logic                      in_range;
  logic [IDX_W-1:0]          idx;
  logic [SW-1:0]             med;
  logic [man_pkg::SUM_W-1:0] sum_new;
  logic                      third;
  logic                      group_done;

  function automatic logic [SW-1:0] median3(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b,
                                            input logic [SW-1:0] c);
    logic [SW-1:0] lo;
    logic [SW-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c > hi) begin
      return hi;
    end else if (c > lo) begin
      return c;
    end
    return lo;
  endfunction

  // queue room gates intake, so a finished group always gets pushed
  assign samples.ready = job_ready;
  assign xfer       = samples.valid && job_ready;
  assign in_range   = {1'b0, samples.channel} < (man_pkg::CH_W + 1)'(NUM_CHANNELS);
  assign idx        = samples.channel[IDX_W-1:0];
  assign med        = median3(win0[idx], win1[idx], samples.sample);
  assign sum_new    = msum[idx] + man_pkg::SUM_W'(med);
  assign third      = slot[idx] == 2'd2;
  assign group_done = third && gcount[idx] == man_pkg::GCOUNT_W'(GROUPS - 1);

  assign job_valid   = xfer && in_range && group_done;
  assign job.channel = samples.channel;
  assign job.sum     = sum_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        slot[i]   <= '0;
        gcount[i] <= '0;
        msum[i]   <= '0;
      end
    end else if (xfer && in_range) begin
      if (!third) begin
        slot[idx] <= slot[idx] + 2'd1;
      end else begin
        slot[idx] <= '0;
        if (group_done) begin
          gcount[idx] <= '0;
          msum[idx]   <= '0;
        end else begin
          gcount[idx] <= gcount[idx] + man_pkg::GCOUNT_W'(1);
          msum[idx]   <= sum_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && in_range) begin
      if (slot[idx] == 2'd0) begin
        win0[idx] <= samples.sample;
      end
      if (slot[idx] == 2'd1) begin
        win1[idx] <= samples.sample;
      end
    end
  end

endmodule

/* rtl/man_back.sv */
// Back half: average, offset/peak stores, level computation, result register.
module man_back #(
  parameter int GROUPS       = man_pkg::GROUPS_DEF,
  parameter int NUM_CHANNELS = man_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [man_pkg::PHASE_W-1:0] phase,
  input  logic                        job_valid,
  output logic                        job_ready,
  input  man_pkg::job_t               job,
  output man_pkg::div_req_t           div_req,
  input  man_pkg::div_rsp_t           div_rsp,
  man_out_if.source                   results
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int AW    = man_pkg::AVG_W;
  localparam int DW    = man_pkg::DIV_W;

  // sum * 16 / GROUPS by reciprocal multiply: with RECIP = ceil(2^RSHIFT / GROUPS)
  // and RSHIFT = NUM_W + clog2(GROUPS) the result is the exact floor for every
  // NUM_W-bit numerator
  localparam int     NUM_W   = man_pkg::SUM_W + man_pkg::FRAC_W;
  localparam int     RSHIFT  = NUM_W + $clog2(GROUPS);
  localparam int     RECIP_W = NUM_W + 1;
  localparam int     PROD_W  = NUM_W + RECIP_W;
  localparam longint RECIP   = ((longint'(1) << RSHIFT) + longint'(GROUPS) - longint'(1))
                               / longint'(GROUPS);

  man_pkg::back_state_t state, state_next;

  logic [AW-1:0]               offset [NUM_CHANNELS];
  logic [AW-1:0]               peak   [NUM_CHANNELS];
  logic [man_pkg::CH_W-1:0]    job_ch;
  logic [man_pkg::SUM_W-1:0]   job_sum;
  logic [PROD_W-1:0]           avg_prod;
  logic [AW-1:0]               avg;
  logic [AW-1:0]               diff;
  logic [DW-1:0]               prod;
  logic [man_pkg::LEVEL_W-1:0] level;
  logic                        sat;
  logic                        pz;

  logic                        res_valid;
  logic [man_pkg::CH_W-1:0]    res_channel;
  logic [AW-1:0]               res_average;
  logic [man_pkg::LEVEL_W-1:0] res_level;
  logic                        res_sat;
  logic                        res_pz;

  logic [IDX_W-1:0] idx;
  logic [AW-1:0]    off_cur;
  logic [AW-1:0]    peak_cur;
  logic             emit;

  assign idx      = job_ch[IDX_W-1:0];
  assign off_cur  = offset[idx];
  assign peak_cur = peak[idx];
  assign emit     = (state == man_pkg::BK_EMIT) && (!res_valid || results.ready);
  assign avg_prod = PROD_W'({job_sum, {man_pkg::FRAC_W{1'b0}}}) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= man_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    div_req    = '0;
    unique case (state)
      man_pkg::BK_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          state_next = man_pkg::BK_AVG;
        end
      end
      man_pkg::BK_AVG: begin
        state_next = man_pkg::BK_APPLY;
      end
      man_pkg::BK_APPLY: begin
        if (phase == man_pkg::PHASE_MEASURE && peak_cur != '0 && avg > off_cur) begin
          state_next = man_pkg::BK_MUL;
        end else begin
          state_next = man_pkg::BK_EMIT;
        end
      end
      man_pkg::BK_MUL: begin
        state_next = man_pkg::BK_LVL_GO;
      end
      man_pkg::BK_LVL_GO: begin
        div_req.start = 1'b1;
        div_req.numer = prod;
        div_req.denom = peak_cur;
        state_next    = man_pkg::BK_DIV_LVL;
      end
      man_pkg::BK_DIV_LVL: begin
        if (div_rsp.done) begin
          state_next = man_pkg::BK_EMIT;
        end
      end
      man_pkg::BK_EMIT: begin
        if (!res_valid || results.ready) begin
          state_next = man_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = man_pkg::BK_IDLE;
      end
    endcase
  end

  // offset/peak stores and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        offset[i] <= '0;
        peak[i]   <= '0;
      end
    end else begin
      if (emit) begin
        res_valid <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (state == man_pkg::BK_APPLY) begin
        unique case (phase)
          man_pkg::PHASE_ZERO: begin
            offset[idx] <= avg;
          end
          man_pkg::PHASE_PEAK: begin
            if (avg > peak_cur) begin
              peak[idx] <= avg;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      man_pkg::BK_IDLE: begin
        if (job_valid) begin
          job_ch  <= job.channel;
          job_sum <= job.sum;
          level   <= '0;
          sat     <= 1'b0;
          pz      <= 1'b0;
        end
      end
      man_pkg::BK_AVG: begin
        // sum * 16 / GROUPS: mean with four fraction bits
        avg <= avg_prod[RSHIFT +: AW];
      end
      man_pkg::BK_APPLY: begin
        diff <= avg - off_cur;
        if (phase == man_pkg::PHASE_MEASURE && peak_cur == '0) begin
          pz <= 1'b1;
        end
      end
      man_pkg::BK_MUL: begin
        prod <= DW'(DW'(diff) * DW'(man_pkg::PERCENT_SCALE));
      end
      man_pkg::BK_DIV_LVL: begin
        if (div_rsp.done) begin
          if (div_rsp.quot > DW'(man_pkg::LEVEL_MAX)) begin
            level <= man_pkg::LEVEL_W'(man_pkg::LEVEL_MAX);
            sat   <= 1'b1;
          end else begin
            level <= div_rsp.quot[man_pkg::LEVEL_W-1:0];
          end
        end
      end
      man_pkg::BK_EMIT: begin
        if (emit) begin
          res_channel <= job_ch;
          res_average <= avg;
          res_level   <= level;
          res_sat     <= sat;
          res_pz      <= pz;
        end
      end
      default: begin
      end
    endcase
  end

  assign results.valid       = res_valid;
  assign results.out_channel = res_channel;
  assign results.average     = res_average;
  assign results.level       = res_level;
  assign results.saturated   = res_sat;
  assign results.peak_zero   = res_pz;

endmodule
